@@ hw/rtl/lpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, codes and helper functions for the lifecycle phase gate.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_CNT_W   = 32;
  localparam int EPOCH_W     = 32;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [OUT_CNT_W-1:0]   out_cnt_t;
  typedef logic [EPOCH_W-1:0]     epoch_t;
  typedef logic [2:0]             phase_t;
  typedef logic [1:0]             level_t;
  typedef logic [1:0]             reason_t;

  localparam cnt_t   CNT_ONE   = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  localparam epoch_t EPOCH_ONE = {{(EPOCH_W-1){1'b0}}, 1'b1};

  localparam logic OP_TRANSITION = 1'b0;
  localparam logic OP_POLICY     = 1'b1;

  localparam phase_t PH_COLD     = 3'd0;
  localparam phase_t PH_SECURE   = 3'd1;
  localparam phase_t PH_READY    = 3'd2;
  localparam phase_t PH_DEGRADED = 3'd3;
  localparam phase_t PH_RECOVERY = 3'd4;

  localparam reason_t RC_ALLOW      = 2'd0;
  localparam reason_t RC_LEVEL      = 2'd1;
  localparam reason_t RC_BAD_TARGET = 2'd2;
  localparam reason_t RC_STRICT     = 2'd3;

  localparam level_t LEVEL_CLAMP = 2'd3;

  localparam logic   RST_STRICT   = 1'b1;
  localparam logic   RST_RANY     = 1'b1;
  localparam level_t RST_T_FLOOR  = 2'd1;
  localparam level_t RST_W_FLOOR  = 2'd2;

  typedef struct packed {
    logic       opcode;
    phase_t     target;
    level_t     level;
    logic       new_strict_forward;
    logic       new_recovery_anytime;
    logic [2:0] new_transition_floor;
    logic [2:0] new_write_floor;
  } req_t;

  typedef struct packed {
    logic     accepted;
    reason_t  reason_code;
    phase_t   phase_now;
    phase_t   target_seen;
    epoch_t   epoch_now;
    out_cnt_t total_moves;
    out_cnt_t denied_moves;
    out_cnt_t recovery_moves;
    logic     strict_now;
    logic     recovery_anytime_now;
    level_t   transition_floor_now;
    level_t   write_floor_now;
  } res_t;

  function automatic level_t clamp_floor(input logic [2:0] v);
    level_t r;
    if (v > 3'(LEVEL_CLAMP)) begin
      r = LEVEL_CLAMP;
    end else begin
      r = v[1:0];
    end
    return r;
  endfunction

  function automatic logic strict_path_ok(input phase_t from, input phase_t to);
    return ((from == PH_COLD)     && (to == PH_SECURE))   ||
           ((from == PH_SECURE)   && (to == PH_READY))    ||
           ((from == PH_READY)    && (to == PH_DEGRADED)) ||
           ((from == PH_DEGRADED) && (to == PH_READY));
  endfunction

  function automatic out_cnt_t cnt_out(input cnt_t c);
    logic [63:0] t;
    t = 64'(c);
    return t[OUT_CNT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/lpg_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_in_stage
// Input register: holds one request until the decision stage takes it.
// ----------------------------------------------------------------------------
module lpg_in_stage import lpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  input  logic take,
  output logic held_valid,
  output req_t held_req
);

  logic valid;
  req_t req;

  assign in_ready   = !valid || take;
  assign held_valid = valid;
  assign held_req   = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_req;
    end
  end

endmodule

@@ hw/rtl/lpg_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_core
// Lifecycle state, policy registers and counters with the gating decision.
// ----------------------------------------------------------------------------
module lpg_core import lpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  req_t req,
  output res_t res
);

  phase_t phase;
  phase_t phase_next;
  phase_t seen_tgt;
  phase_t seen_tgt_next;
  logic   strict;
  logic   strict_next;
  logic   rany;
  logic   rany_next;
  level_t t_floor;
  level_t t_floor_next;
  level_t w_floor;
  level_t w_floor_next;
  epoch_t epoch;
  epoch_t epoch_next;
  cnt_t   total;
  cnt_t   total_next;
  cnt_t   denied;
  cnt_t   denied_next;
  cnt_t   rec_cnt;
  cnt_t   rec_cnt_next;
  reason_t reason_next;
  logic   acc;
  logic   path_ok;

  always_comb begin
    phase_next       = phase;
    seen_tgt_next    = seen_tgt;
    strict_next      = strict;
    rany_next        = rany;
    t_floor_next     = t_floor;
    w_floor_next     = w_floor;
    epoch_next       = epoch;
    total_next       = total;
    denied_next      = denied;
    rec_cnt_next     = rec_cnt;
    reason_next      = RC_ALLOW;
    acc              = 1'b0;
    path_ok          = ((req.target == PH_RECOVERY) && rany) || !strict ||
                       strict_path_ok(phase, req.target);
    if (req.opcode == OP_POLICY) begin
      if (req.level < w_floor) begin
        reason_next = RC_LEVEL;
      end else begin
        strict_next  = req.new_strict_forward;
        rany_next    = req.new_recovery_anytime;
        t_floor_next = clamp_floor(req.new_transition_floor);
        w_floor_next = clamp_floor(req.new_write_floor);
        epoch_next   = epoch + EPOCH_ONE;
        acc          = 1'b1;
      end
    end else begin
      if (req.target > PH_RECOVERY) begin
        denied_next = denied + CNT_ONE;
        reason_next = RC_BAD_TARGET;
      end else if (req.level < t_floor) begin
        denied_next = denied + CNT_ONE;
        reason_next = RC_LEVEL;
      end else begin
        seen_tgt_next = req.target;
        if (!path_ok) begin
          denied_next = denied + CNT_ONE;
          reason_next = RC_STRICT;
        end else begin
          phase_next = req.target;
          total_next = total + CNT_ONE;
          if (req.target == PH_RECOVERY) begin
            rec_cnt_next = rec_cnt + CNT_ONE;
          end
          acc = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.accepted             = acc;
    res.reason_code          = reason_next;
    res.phase_now            = phase_next;
    res.target_seen          = seen_tgt_next;
    res.epoch_now            = epoch_next;
    res.total_moves          = cnt_out(total_next);
    res.denied_moves         = cnt_out(denied_next);
    res.recovery_moves       = cnt_out(rec_cnt_next);
    res.strict_now           = strict_next;
    res.recovery_anytime_now = rany_next;
    res.transition_floor_now = t_floor_next;
    res.write_floor_now      = w_floor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COLD;
      seen_tgt    <= PH_COLD;
      strict      <= RST_STRICT;
      rany        <= RST_RANY;
      t_floor     <= RST_T_FLOOR;
      w_floor     <= RST_W_FLOOR;
      epoch       <= EPOCH_ONE;
      total       <= '0;
      denied      <= '0;
      rec_cnt     <= '0;
    end else if (load) begin
      phase       <= phase_next;
      seen_tgt    <= seen_tgt_next;
      strict      <= strict_next;
      rany        <= rany_next;
      t_floor     <= t_floor_next;
      w_floor     <= w_floor_next;
      epoch       <= epoch_next;
      total       <= total_next;
      denied      <= denied_next;
      rec_cnt     <= rec_cnt_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_RECOVERY && seen_tgt <= PH_RECOVERY)
    else $error("phase register out of range");

  a_reason_acc: assert property (@(posedge clk) disable iff (rst)
    load && res.reason_code != RC_ALLOW |-> !res.accepted)
    else $error("denied request flagged accepted");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(phase) && $stable(epoch) && $stable(total) && $stable(denied))
    else $error("state changed without a request");

  a_move_count: assert property (@(posedge clk) disable iff (rst)
    load && req.opcode == OP_TRANSITION && acc |=> total == $past(total) + CNT_ONE)
    else $error("accepted move not counted");

  a_epoch_bump: assert property (@(posedge clk) disable iff (rst)
    load && !(req.opcode == OP_POLICY && acc) |=> $stable(epoch))
    else $error("epoch moved without policy write");
`endif

endmodule

@@ hw/rtl/lpg_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module lpg_out_stage import lpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  input  res_t src_res,
  output logic load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid;
  res_t res;

  assign load      = src_valid && (!valid || out_ready);
  assign out_valid = valid;
  assign out_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || out_ready) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= src_res;
    end
  end

endmodule

@@ hw/rtl/lifecycle_phase_gate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifecycle_phase_gate_top
// Five-phase lifecycle gate: transition requests and policy writes in,
// one status result out for every request.
// ----------------------------------------------------------------------------
// usage
//   s_* takes one request per handshake; s_tuser is the opcode
//   (transition request or policy write), s_tdata carries the rest.
//   m_* returns exactly one result per request, in request order.
//   a request taken at one edge sits in the input register, is decided
//   and lands in the result register at the next edge it can move,
//   and m_tvalid rises at that same edge.
//   throughput is one request per cycle with m_tready high; the gating
//   decision and the counter updates are one short combinational step,
//   and the next request sees the updated phase and policy directly.
//   reset puts the phase in cold boot, strict and recovery-anytime on,
//   transition floor 1, write floor 2, epoch 1, counters zero.
//   when m_tready is low the result holds, the input register fills,
//   and s_tready drops until the receiver takes the result.
// ----------------------------------------------------------------------------
module lifecycle_phase_gate_top import lpg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // target[2:0] level[4:3] new_strict_forward[5] new_recovery_anytime[6]
  // new_transition_floor[9:7] new_write_floor[12:10] zero[15:13]
  input  logic [15:0]  s_tdata,
  // opcode[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accepted[0] reason_code[2:1] phase_now[5:3] target_seen[8:6]
  // epoch_now[40:9] total_moves[72:41] denied_moves[104:73]
  // recovery_moves[136:105] strict_now[137] recovery_anytime_now[138]
  // transition_floor_now[140:139] write_floor_now[142:141] zero[143]
  output logic [143:0] m_tdata
);

  req_t in_req;
  req_t held_req;
  logic held_valid;
  logic load;
  res_t core_res;
  res_t out_res;

  always_comb begin
    in_req.opcode               = s_tuser;
    in_req.target               = s_tdata[2:0];
    in_req.level                = s_tdata[4:3];
    in_req.new_strict_forward   = s_tdata[5];
    in_req.new_recovery_anytime = s_tdata[6];
    in_req.new_transition_floor = s_tdata[9:7];
    in_req.new_write_floor      = s_tdata[12:10];
  end

  lpg_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (in_req),
    .take       (load),
    .held_valid (held_valid),
    .held_req   (held_req)
  );

  lpg_core u_core (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .req  (held_req),
    .res  (core_res)
  );

  lpg_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .src_valid (held_valid),
    .src_res   (core_res),
    .load      (load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  always_comb begin
    m_tdata          = '0;
    m_tdata[0]       = out_res.accepted;
    m_tdata[2:1]     = out_res.reason_code;
    m_tdata[5:3]     = out_res.phase_now;
    m_tdata[8:6]     = out_res.target_seen;
    m_tdata[40:9]    = out_res.epoch_now;
    m_tdata[72:41]   = out_res.total_moves;
    m_tdata[104:73]  = out_res.denied_moves;
    m_tdata[136:105] = out_res.recovery_moves;
    m_tdata[137]     = out_res.strict_now;
    m_tdata[138]     = out_res.recovery_anytime_now;
    m_tdata[140:139] = out_res.transition_floor_now;
    m_tdata[142:141] = out_res.write_floor_now;
  end

endmodule
